/* hdl/gpl_pkg.sv */
`default_nettype none

package gpl_pkg;

   localparam int unsigned PIN_COUNT_DEFAULT = 16;
   localparam int unsigned PORT_WIDTH        = 16;
   localparam int unsigned BUS_WIDTH         = 32;
   localparam int unsigned NIBBLES_PER_WORD  = 8;

   localparam logic [BUS_WIDTH-1:0] CFG_RESET_VALUE = 32'h4444_4444;

   // position of the key bit in the lock register
   localparam int unsigned LOCK_KEY_BIT = 16;

   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   typedef enum logic [2:0] {
      SEL_CFG_LOW  = 3'd0,
      SEL_CFG_HIGH = 3'd1,
      SEL_INPUT    = 3'd2,
      SEL_LATCH    = 3'd3,
      SEL_SET_RST  = 3'd4,
      SEL_RESET    = 3'd5,
      SEL_LOCK     = 3'd6
   } gpl_sel_type;

   // lock key sequence progress
   typedef enum logic [1:0] {
      KEY_IDLE    = 2'd0,
      KEY_ARMED   = 2'd1,
      KEY_CONFIRM = 2'd2,
      KEY_READY   = 2'd3
   } gpl_key_type;

   typedef struct packed {
      logic                  cmd;
      logic [2:0]            reg_sel;
      logic [BUS_WIDTH-1:0]  wdata;
      logic [PORT_WIDTH-1:0] pins_in;
   } gpl_req_type;

   typedef struct packed {
      logic [BUS_WIDTH-1:0]  rdata;
      logic [PORT_WIDTH-1:0] pins_out;
      logic                  lock_active;
   } gpl_rsp_type;

endpackage

`default_nettype wire

/* hdl/gpio_port_with_config_lock.sv */
`default_nettype none

// 16-pin gpio port behind a small register bus. every request beat is one read or
// write to one of seven registers (cfg low, cfg high, input, output latch, set/reset,
// reset, lock) along with the sampled pin levels; every request yields exactly one
// response beat carrying the read data, the output latch after the access and the
// lock status. the block takes one request per cycle: all the work of an access is
// one level of logic between the request handshake and the response register, so a
// response appears in the cycle after its request is taken. the response register is
// the only buffer: a new request is taken whenever the response register is empty
// or its beat is being taken in the same cycle, so req_stall follows rsp_stall only
// while a response is held. pins at or above PIN_COUNT read as zero and have no latch
// or lock flops; the configuration words are always kept at full width. once the
// write/write/write/read key sequence completes, the configuration nibbles of the
// locked pins are frozen until reset.
module gpio_port_with_config_lock
   import gpl_pkg::*;
#(
   parameter int unsigned PIN_COUNT = PIN_COUNT_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire gpl_req_type req_data,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output gpl_rsp_type      rsp_data
);

   // architectural state
   logic [BUS_WIDTH-1:0] cfg_low_ff,   cfg_low_in;
   logic [BUS_WIDTH-1:0] cfg_high_ff,  cfg_high_in;
   logic [PIN_COUNT-1:0] latch_ff,     latch_in;
   logic [PIN_COUNT-1:0] lock_bits_ff, lock_bits_in;
   logic                 lock_key_ff,  lock_key_in;
   gpl_key_type          key_step_ff,  key_step_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   gpl_rsp_type          rsp_data_ff,  rsp_data_in;

   logic                 req_fire;
   logic                 is_write;
   logic                 is_lock_access;
   logic                 key_bit;
   logic                 same_bits;
   logic [PIN_COUNT-1:0] wdata_pins;
   logic [PIN_COUNT-1:0] pins_sampled;
   logic [PORT_WIDTH-1:0] lock_wide;
   logic [BUS_WIDTH-1:0] frozen_low;
   logic [BUS_WIDTH-1:0] frozen_high;
   logic [BUS_WIDTH-1:0] rdata;

   // request taken unless a held response is still stalled
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_fire  = req_valid & ~req_stall;

   assign is_write       = (req_data.cmd == CMD_WRITE);
   assign is_lock_access = req_fire && (req_data.reg_sel == SEL_LOCK) && !lock_key_ff;
   assign key_bit        = req_data.wdata[LOCK_KEY_BIT];
   assign wdata_pins     = req_data.wdata[PIN_COUNT-1:0];
   assign pins_sampled   = req_data.pins_in[PIN_COUNT-1:0];
   assign same_bits      = (wdata_pins == lock_bits_ff);
   assign lock_wide      = PORT_WIDTH'(lock_bits_ff);

   // nibble masks of frozen pins, low word covers pins 0..7, high word pins 8..15
   always_comb begin
      for (int i = 0; i < NIBBLES_PER_WORD; i++) begin
         frozen_low[4*i +: 4]  = {4{lock_key_ff & lock_wide[i]}};
         frozen_high[4*i +: 4] = {4{lock_key_ff & lock_wide[NIBBLES_PER_WORD + i]}};
      end
   end

   // key sequence: next state
   always_comb begin
      key_step_in = key_step_ff;
      if (is_lock_access) begin
         if (is_write) begin
            unique case (key_step_ff)
               KEY_IDLE:    key_step_in = key_bit ? KEY_ARMED : KEY_IDLE;
               KEY_ARMED:   key_step_in = (!key_bit && same_bits) ? KEY_CONFIRM :
                                          (key_bit ? KEY_ARMED : KEY_IDLE);
               KEY_CONFIRM: key_step_in = (key_bit && same_bits) ? KEY_READY :
                                          (key_bit ? KEY_ARMED : KEY_IDLE);
               KEY_READY:   key_step_in = key_bit ? KEY_ARMED : KEY_IDLE;
               default:     key_step_in = KEY_IDLE;
            endcase
         end else begin
            // any lock read ends the sequence
            key_step_in = KEY_IDLE;
         end
      end
   end

   // key sequence: outputs (key and lock bits)
   always_comb begin
      lock_key_in  = lock_key_ff;
      lock_bits_in = lock_bits_ff;
      if (is_lock_access) begin
         if (is_write) begin
            lock_bits_in = wdata_pins;
         end else if (key_step_ff == KEY_READY) begin
            lock_key_in = 1'b1;
         end
      end
   end

   // register file writes and read mux
   always_comb begin
      cfg_low_in  = cfg_low_ff;
      cfg_high_in = cfg_high_ff;
      latch_in    = latch_ff;
      rdata       = '0;
      if (req_fire) begin
         if (is_write) begin
            case (req_data.reg_sel)
               SEL_CFG_LOW:  cfg_low_in  = (cfg_low_ff & frozen_low) |
                                           (req_data.wdata & ~frozen_low);
               SEL_CFG_HIGH: cfg_high_in = (cfg_high_ff & frozen_high) |
                                           (req_data.wdata & ~frozen_high);
               SEL_LATCH:    latch_in    = wdata_pins;
               // set wins where both halves name a pin
               SEL_SET_RST:  latch_in    = (latch_ff &
                                            ~req_data.wdata[PORT_WIDTH +: PIN_COUNT]) |
                                           wdata_pins;
               SEL_RESET:    latch_in    = latch_ff & ~wdata_pins;
               default:      ;
            endcase
         end else begin
            case (req_data.reg_sel)
               SEL_CFG_LOW:  rdata = cfg_low_ff;
               SEL_CFG_HIGH: rdata = cfg_high_ff;
               SEL_INPUT:    rdata = BUS_WIDTH'(pins_sampled);
               SEL_LATCH:    rdata = BUS_WIDTH'(latch_ff);
               SEL_LOCK:     rdata = BUS_WIDTH'({lock_key_ff, lock_wide});
               default:      rdata = '0;
            endcase
         end
      end
   end

   // response register load
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_fire) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.rdata        = rdata;
         rsp_data_in.pins_out     = PORT_WIDTH'(latch_in);
         rsp_data_in.lock_active  = lock_key_in;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_low_ff   <= CFG_RESET_VALUE;
         cfg_high_ff  <= CFG_RESET_VALUE;
         latch_ff     <= '0;
         lock_bits_ff <= '0;
         lock_key_ff  <= 1'b0;
         key_step_ff  <= KEY_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_low_ff   <= cfg_low_in;
         cfg_high_ff  <= cfg_high_in;
         latch_ff     <= latch_in;
         lock_bits_ff <= lock_bits_in;
         lock_key_ff  <= lock_key_in;
         key_step_ff  <= key_step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* hdl/gpl_checker.sv */
`default_nettype none

module gpl_checker
   import gpl_pkg::*;
#(
   parameter int unsigned PIN_COUNT = PIN_COUNT_DEFAULT
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire gpl_req_type req_data,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire gpl_rsp_type rsp_data
);

   localparam logic [PORT_WIDTH-1:0] PinMask =
      PORT_WIDTH'((33'd1 << PIN_COUNT) - 33'd1);

   logic        req_fire;
   logic        rsp_fire;
   logic        pending_ff,   pending_in;
   logic        locked_ff,    locked_in;
   gpl_req_type last_req_ff;

   assign req_fire = req_valid & ~req_stall;
   assign rsp_fire = rsp_valid & ~rsp_stall;

   always_comb begin
      pending_in = pending_ff;
      if (req_fire) begin
         pending_in = 1'b1;
      end else if (rsp_fire) begin
         pending_in = 1'b0;
      end
      locked_in = locked_ff | (rsp_fire & rsp_data.lock_active);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         locked_ff  <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         locked_ff  <= locked_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         last_req_ff <= req_data;
      end
   end

   // a held response beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response beat changed while stalled");

   // never more than one request in flight
   a_one_pending: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> !pending_ff || rsp_fire)
      else $error("request taken while an earlier response is still held");

   // writes return zero read data
   a_write_rdata: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && pending_ff && (last_req_ff.cmd == CMD_WRITE) |-> rsp_data.rdata == '0)
      else $error("write access returned nonzero read data");

   // a latch write shows up on the pins
   a_latch_echo: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && pending_ff && (last_req_ff.cmd == CMD_WRITE) &&
      (last_req_ff.reg_sel == SEL_LATCH)
      |-> rsp_data.pins_out == (last_req_ff.wdata[PORT_WIDTH-1:0] & PinMask))
      else $error("output latch write not reflected on pins_out");

   // lock holds until reset
   a_lock_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && locked_ff |-> rsp_data.lock_active)
      else $error("lock released without reset");

endmodule

bind gpio_port_with_config_lock gpl_checker #(
   .PIN_COUNT (PIN_COUNT)
) u_gpl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

/* tb/sv/gpio_port_with_config_lock_test.sv */
module gpio_port_with_config_lock_test;
   timeunit 1ns;
   timeprecision 1ps;

   import gpl_pkg::*;

   // long receiver hold-off used to back the port up into its request side
   localparam int HOLD_CYCLES = 300;
   // selector value with no register behind it
   localparam logic [2:0] SEL_UNUSED = 3'd7;

   // ways a lock key sequence is spoiled on purpose
   typedef enum int {
      FLAW_NONE,
      FLAW_CONFIRM_BITS,
      FLAW_CONFIRM_KEY,
      FLAW_FINAL_BITS,
      FLAW_FINAL_KEY,
      FLAW_WRITE_FOR_READ,
      FLAW_EARLY_READ
   } key_flaw_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   gpl_req_type req_data  = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   gpl_rsp_type rsp_data;

   // bus accesses waiting for the driver, and replies the port still owes
   gpl_req_type pending_accesses[$];
   gpl_rsp_type expected_replies[$];

   // idling knobs, percent of cycles
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   // hold-off bookkeeping for the receiver
   int holds_asked = 0;
   int holds_done  = 0;
   int hold_left   = 0;

   logic req_taken = 1'b0;
   int   mismatch_count = 0;

   // predicted register state of the port
   logic [31:0]  port_cfg_low;
   logic [31:0]  port_cfg_high;
   logic [15:0]  port_latch;
   logic [15:0]  port_lock_bits;
   logic         port_lock_key;
   gpl_key_type  port_key_step;

   gpio_port_with_config_lock dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // 20 ns clock
   always #10 clock = ~clock;

   // nibble mask of the configuration fields that the lock freezes
   function automatic logic [31:0] frozen_nibbles(logic [7:0] locked_pins);
      logic [31:0] mask;
      mask = '0;
      if (port_lock_key) begin
         for (int i = 0; i < NIBBLES_PER_WORD; i++) begin
            if (locked_pins[i]) begin
               mask[4*i +: 4] = 4'hf;
            end
         end
      end
      return mask;
   endfunction

   // apply one bus access to the predicted state and return the reply it earns
   function automatic gpl_rsp_type apply_access(gpl_req_type access);
      gpl_rsp_type reply;
      logic [31:0] frozen;
      logic        key_bit;
      logic        bits_match;
      reply      = '0;
      key_bit    = access.wdata[LOCK_KEY_BIT];
      bits_match = (access.wdata[15:0] == port_lock_bits);
      if (access.cmd == CMD_WRITE) begin
         case (access.reg_sel)
            SEL_CFG_LOW: begin
               frozen = frozen_nibbles(port_lock_bits[7:0]);
               port_cfg_low = (port_cfg_low & frozen) | (access.wdata & ~frozen);
            end
            SEL_CFG_HIGH: begin
               frozen = frozen_nibbles(port_lock_bits[15:8]);
               port_cfg_high = (port_cfg_high & frozen) | (access.wdata & ~frozen);
            end
            SEL_LATCH: port_latch = access.wdata[15:0];
            // set wins where both halves name a pin
            SEL_SET_RST: port_latch = (port_latch & ~access.wdata[31:16]) | access.wdata[15:0];
            SEL_RESET: port_latch = port_latch & ~access.wdata[15:0];
            SEL_LOCK: begin
               // lock writes are dead once the key is set
               if (!port_lock_key) begin
                  if (port_key_step == KEY_IDLE && key_bit) begin
                     port_key_step = KEY_ARMED;
                  end else if (port_key_step == KEY_ARMED && !key_bit && bits_match) begin
                     port_key_step = KEY_CONFIRM;
                  end else if (port_key_step == KEY_CONFIRM && key_bit && bits_match) begin
                     port_key_step = KEY_READY;
                  end else begin
                     // wrong step: abort, or restart when the key bit is set
                     port_key_step = key_bit ? KEY_ARMED : KEY_IDLE;
                  end
                  port_lock_bits = access.wdata[15:0];
               end
            end
            default: ;
         endcase
      end else begin
         case (access.reg_sel)
            SEL_CFG_LOW:  reply.rdata = port_cfg_low;
            SEL_CFG_HIGH: reply.rdata = port_cfg_high;
            SEL_INPUT:    reply.rdata = {16'h0, access.pins_in};
            SEL_LATCH:    reply.rdata = {16'h0, port_latch};
            SEL_LOCK: begin
               // the read that completes the key still shows the old key bit
               reply.rdata = {15'h0, port_lock_key, port_lock_bits};
               if (!port_lock_key) begin
                  if (port_key_step == KEY_READY) begin
                     port_lock_key = 1'b1;
                  end
                  port_key_step = KEY_IDLE;
               end
            end
            default: reply.rdata = '0;
         endcase
      end
      reply.pins_out    = port_latch;
      reply.lock_active = port_lock_key;
      return reply;
   endfunction

   function automatic gpl_req_type make_beat(logic cmd, logic [2:0] sel, logic [31:0] wdata,
                                             logic [15:0] pins);
      gpl_req_type access;
      access.cmd     = cmd;
      access.reg_sel = sel;
      access.wdata   = wdata;
      access.pins_in = pins;
      return access;
   endfunction

   // mostly random words, with the all-zero and all-one extremes mixed in
   function automatic logic [31:0] pick_word();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return $urandom();
      endcase
   endfunction

   // one lock key sequence with random content and unrelated accesses in between;
   // unless it is meant to complete, one step is spoiled so the key never sets
   task automatic queue_key_sequence(input bit complete);
      logic [15:0]  pin_set;
      logic [2:0]   other_sel;
      key_flaw_type flaw;
      gpl_req_type  access;
      case ($urandom_range(3))
         0: pin_set = '0;
         1: pin_set = '1;
         default: pin_set = 16'($urandom());
      endcase
      if (complete) begin
         pin_set = 16'($urandom());
      end
      flaw = complete ? FLAW_NONE
                      : key_flaw_type'($urandom_range(FLAW_EARLY_READ, FLAW_CONFIRM_BITS));
      for (int step = 0; step < 4; step++) begin
         if (step == 3) begin
            access = make_beat(CMD_READ, SEL_LOCK, $urandom(), 16'($urandom()));
         end else begin
            access = make_beat(CMD_WRITE, SEL_LOCK, $urandom(), 16'($urandom()));
            access.wdata[LOCK_KEY_BIT] = (step != 1);
            access.wdata[15:0]         = pin_set;
         end
         case (flaw)
            FLAW_CONFIRM_BITS:
               if (step == 1) access.wdata[15:0] ^= 16'($urandom_range(65535, 1));
            FLAW_CONFIRM_KEY:  if (step == 1) access.wdata[LOCK_KEY_BIT] = 1'b1;
            FLAW_FINAL_BITS:
               if (step == 2) access.wdata[15:0] ^= 16'($urandom_range(65535, 1));
            FLAW_FINAL_KEY:    if (step == 2) access.wdata[LOCK_KEY_BIT] = 1'b0;
            FLAW_WRITE_FOR_READ: if (step == 3) access.cmd = CMD_WRITE;
            FLAW_EARLY_READ:
               if (step == 2) access = make_beat(CMD_READ, SEL_LOCK, $urandom(),
                                                 16'($urandom()));
            default: ;
         endcase
         pending_accesses.push_back(access);
         // traffic to other registers must not disturb the sequence
         repeat ($urandom_range(2)) begin
            other_sel = 3'($urandom_range(6));
            if (other_sel == SEL_LOCK) begin
               other_sel = SEL_UNUSED;
            end
            pending_accesses.push_back(make_beat(1'($urandom_range(1)), other_sel,
                                                 pick_word(), 16'($urandom())));
         end
      end
   endtask

   // random traffic: plain accesses to any selector plus spoiled key sequences
   task automatic queue_traffic(input int count);
      int stop_at;
      stop_at = pending_accesses.size() + count;
      while (pending_accesses.size() < stop_at) begin
         if ($urandom_range(99) < 30) begin
            queue_key_sequence(1'b0);
         end else begin
            pending_accesses.push_back(make_beat(1'($urandom_range(1)),
                                                 3'($urandom_range(7)),
                                                 pick_word(), 16'($urandom())));
         end
      end
   endtask

   // wait until every beat is sent and answered, then step to a rising edge
   task automatic wait_for_drain();
      while (pending_accesses.size() != 0 || req_valid || expected_replies.size() != 0) begin
         @(negedge clock);
      end
      @(posedge clock);
   endtask

   // request driver: a beat stays put until taken, then the next may follow
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_accesses.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data  <= pending_accesses.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // reply receiver: random stalls, or a long hold-off when one is asked for
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_done < holds_asked) begin
         rsp_stall  <= 1'b1;
         hold_left  <= HOLD_CYCLES - 1;
         holds_done <= holds_done + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // monitor: predict on every taken request beat, check every taken reply beat
   always @(posedge clock) begin : reply_check
      gpl_rsp_type want;
      req_taken <= req_valid && !req_stall;
      if (reset) begin
         port_cfg_low   = CFG_RESET_VALUE;
         port_cfg_high  = CFG_RESET_VALUE;
         port_latch     = '0;
         port_lock_bits = '0;
         port_lock_key  = 1'b0;
         port_key_step  = KEY_IDLE;
      end else begin
         if (req_valid && !req_stall) begin
            expected_replies.push_back(apply_access(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_replies.size() == 0) begin
               $display("%0t: reply beat with nothing expected, actual %h", $time, rsp_data);
               mismatch_count++;
            end else begin
               want = expected_replies.pop_front();
               if (rsp_data.rdata !== want.rdata) begin
                  $display("%0t: rdata expected %h actual %h", $time, want.rdata,
                           rsp_data.rdata);
                  mismatch_count++;
               end
               if (rsp_data.pins_out !== want.pins_out) begin
                  $display("%0t: pins_out expected %h actual %h", $time, want.pins_out,
                           rsp_data.pins_out);
                  mismatch_count++;
               end
               if (rsp_data.lock_active !== want.lock_active) begin
                  $display("%0t: lock_active expected %b actual %b", $time, want.lock_active,
                           rsp_data.lock_active);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // stimulus, phase by phase
   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset values, extremes, every register both ways
      pending_accesses.push_back(make_beat(CMD_READ,  SEL_CFG_LOW,  '0, '0));
      pending_accesses.push_back(make_beat(CMD_READ,  SEL_CFG_HIGH, '0, '0));
      pending_accesses.push_back(make_beat(CMD_WRITE, SEL_CFG_LOW,  '1, '1));
      pending_accesses.push_back(make_beat(CMD_WRITE, SEL_CFG_HIGH, '0, '0));
      pending_accesses.push_back(make_beat(CMD_READ,  SEL_CFG_LOW,  '1, '0));
      pending_accesses.push_back(make_beat(CMD_READ,  SEL_CFG_HIGH, '0, '1));
      pending_accesses.push_back(make_beat(CMD_READ,  SEL_INPUT,    '0, '1));
      pending_accesses.push_back(make_beat(CMD_READ,  SEL_INPUT,    '1, '0));
      // upper half of a latch write is dropped
      pending_accesses.push_back(make_beat(CMD_WRITE, SEL_LATCH,    '1, '0));
      pending_accesses.push_back(make_beat(CMD_READ,  SEL_LATCH,    '0, '0));
      // set and reset naming the same pins: set wins
      pending_accesses.push_back(make_beat(CMD_WRITE, SEL_SET_RST, 32'hffff_00f0, '0));
      pending_accesses.push_back(make_beat(CMD_WRITE, SEL_SET_RST, 32'h0000_0000, '0));
      pending_accesses.push_back(make_beat(CMD_WRITE, SEL_SET_RST, 32'h00f0_ff00, '0));
      pending_accesses.push_back(make_beat(CMD_WRITE, SEL_RESET,   32'hffff_0f00, '0));
      // write-only registers read as zero
      pending_accesses.push_back(make_beat(CMD_READ,  SEL_SET_RST, '1, '1));
      pending_accesses.push_back(make_beat(CMD_READ,  SEL_RESET,   '1, '1));
      // input register ignores writes, unused selector does nothing
      pending_accesses.push_back(make_beat(CMD_WRITE, SEL_INPUT,   '1, '1));
      pending_accesses.push_back(make_beat(CMD_WRITE, SEL_UNUSED,  '1, '1));
      pending_accesses.push_back(make_beat(CMD_READ,  SEL_UNUSED,  '1, '1));
      // key sequence broken by mismatching bits, then by an early read
      pending_accesses.push_back(make_beat(CMD_READ,  SEL_LOCK,    '0, '0));
      pending_accesses.push_back(make_beat(CMD_WRITE, SEL_LOCK,    32'h0001_00a5, '0));
      pending_accesses.push_back(make_beat(CMD_WRITE, SEL_LOCK,    32'h0000_005a, '0));
      pending_accesses.push_back(make_beat(CMD_READ,  SEL_LOCK,    '0, '0));
      pending_accesses.push_back(make_beat(CMD_WRITE, SEL_LOCK,    32'hffff_ffff, '0));
      pending_accesses.push_back(make_beat(CMD_READ,  SEL_LOCK,    '0, '0));

      // no idling at all
      queue_traffic(170);
      wait_for_drain();

      // sender mostly idle
      send_idle_pct = 83;
      queue_traffic(170);
      wait_for_drain();

      // receiver mostly stalling
      send_idle_pct = 0;
      rsp_stall_pct = 83;
      queue_traffic(170);
      wait_for_drain();

      // long hold-off while the sender keeps offering beats
      rsp_stall_pct = 0;
      holds_asked++;
      queue_traffic(120);
      wait_for_drain();

      // both sides idle now and then; the key finally sets midway
      send_idle_pct = 17;
      rsp_stall_pct = 17;
      queue_traffic(110);
      queue_key_sequence(1'b1);
      // locked pins keep their nibbles, lock writes are ignored
      pending_accesses.push_back(make_beat(CMD_WRITE, SEL_CFG_LOW,  '0, '0));
      pending_accesses.push_back(make_beat(CMD_WRITE, SEL_CFG_HIGH, '0, '0));
      pending_accesses.push_back(make_beat(CMD_READ,  SEL_CFG_LOW,  '0, '0));
      pending_accesses.push_back(make_beat(CMD_READ,  SEL_CFG_HIGH, '0, '0));
      pending_accesses.push_back(make_beat(CMD_WRITE, SEL_CFG_LOW,  '1, '1));
      pending_accesses.push_back(make_beat(CMD_WRITE, SEL_CFG_HIGH, '1, '1));
      pending_accesses.push_back(make_beat(CMD_WRITE, SEL_LOCK,     '1, '1));
      pending_accesses.push_back(make_beat(CMD_READ,  SEL_LOCK,     '0, '0));
      queue_traffic(110);
      wait_for_drain();

      // let any late beat surface before the verdict
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
